[rtl/cpu_16bit_load_unit_assert.svh]
// Assertion macros used by the checker module.
`ifndef CPU_16BIT_LOAD_UNIT_ASSERT_SVH
`define CPU_16BIT_LOAD_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CL16_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is held.
`define CL16_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[rtl/cl16_pkg.sv]
`default_nettype none

package cl16_pkg;

    // Opcodes of the 16-bit load group
    localparam logic [7:0] OP_LD_BC_N16 = 8'h01;
    localparam logic [7:0] OP_LD_DE_N16 = 8'h11;
    localparam logic [7:0] OP_LD_HL_N16 = 8'h21;
    localparam logic [7:0] OP_LD_SP_N16 = 8'h31;
    localparam logic [7:0] OP_LD_A16_SP = 8'h08;
    localparam logic [7:0] OP_POP_BC    = 8'hC1;
    localparam logic [7:0] OP_POP_DE    = 8'hD1;
    localparam logic [7:0] OP_POP_HL    = 8'hE1;
    localparam logic [7:0] OP_POP_AF    = 8'hF1;
    localparam logic [7:0] OP_PUSH_BC   = 8'hC5;
    localparam logic [7:0] OP_PUSH_DE   = 8'hD5;
    localparam logic [7:0] OP_PUSH_HL   = 8'hE5;
    localparam logic [7:0] OP_PUSH_AF   = 8'hF5;
    localparam logic [7:0] OP_LD_HL_SPE = 8'hF8;
    localparam logic [7:0] OP_LD_SP_HL  = 8'hF9;

    // Register pair selected by opcode bits 5..4
    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_AF = 2'd3;

    // POP AF clears the low nibble of F
    localparam logic [15:0] AF_POP_MASK = 16'hFFF0;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        CLS_LD_PAIR_IMM,
        CLS_LD_SP_IMM,
        CLS_ST_SP,
        CLS_POP,
        CLS_PUSH,
        CLS_LD_HL_SPE,
        CLS_LD_SP_HL,
        CLS_UNSUP
    } op_class_t;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [15:0] operand_word;
        logic [15:0] pop_word;
    } in_item_t;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        last;
        logic        unsupported;
        logic [15:0] sp_value;
        logic [15:0] hl_value;
    } out_item_t;

    // Decoded instruction held in the queue
    typedef struct packed {
        op_class_t   cls;
        logic [1:0]  sel;
        logic [15:0] operand;
        logic [15:0] pop_word;
    } queue_entry_t;

endpackage

`default_nettype wire

[rtl/cl16_front.sv]
`default_nettype none

module cl16_front (
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire cl16_pkg::in_item_t    s_payload,
    input  wire logic                  queue_full,
    output logic                       push,
    output cl16_pkg::queue_entry_t     entry
);

    // Accept whenever the queue has room
    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    // Classify the opcode
    always_comb begin
        entry.sel      = s_payload.opcode[5:4];
        entry.operand  = s_payload.operand_word;
        entry.pop_word = s_payload.pop_word;
        unique case (s_payload.opcode)
            cl16_pkg::OP_LD_BC_N16,
            cl16_pkg::OP_LD_DE_N16,
            cl16_pkg::OP_LD_HL_N16: entry.cls = cl16_pkg::CLS_LD_PAIR_IMM;
            cl16_pkg::OP_LD_SP_N16: entry.cls = cl16_pkg::CLS_LD_SP_IMM;
            cl16_pkg::OP_LD_A16_SP: entry.cls = cl16_pkg::CLS_ST_SP;
            cl16_pkg::OP_POP_BC,
            cl16_pkg::OP_POP_DE,
            cl16_pkg::OP_POP_HL,
            cl16_pkg::OP_POP_AF:    entry.cls = cl16_pkg::CLS_POP;
            cl16_pkg::OP_PUSH_BC,
            cl16_pkg::OP_PUSH_DE,
            cl16_pkg::OP_PUSH_HL,
            cl16_pkg::OP_PUSH_AF:   entry.cls = cl16_pkg::CLS_PUSH;
            cl16_pkg::OP_LD_HL_SPE: entry.cls = cl16_pkg::CLS_LD_HL_SPE;
            cl16_pkg::OP_LD_SP_HL:  entry.cls = cl16_pkg::CLS_LD_SP_HL;
            default:                entry.cls = cl16_pkg::CLS_UNSUP;
        endcase
    end

endmodule

`default_nettype wire

[rtl/cl16_queue.sv]
`default_nettype none

module cl16_queue #(
    parameter int DEPTH = cl16_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire cl16_pkg::queue_entry_t  entry_in,
    output logic                         full,
    output logic                         head_valid,
    output cl16_pkg::queue_entry_t       head,
    input  wire logic                    pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cl16_pkg::queue_entry_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= entry_in;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/cl16_back.sv]
`default_nettype none

module cl16_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    head_valid,
    input  wire cl16_pkg::queue_entry_t  head,
    output logic                         pop,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output cl16_pkg::out_item_t          m_payload
);

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } phase_t;

    phase_t              phase_reg;
    logic                m_valid_reg;
    cl16_pkg::out_item_t m_payload_reg;
    logic [15:0]         sp_reg, sp_next;
    logic [15:0]         pair_reg [4];
    logic [15:0]         pair_next [4];
    logic [15:0]         hold_addr_reg, hold_addr_next;
    logic [7:0]          hold_data_reg, hold_data_next;

    logic                issue;
    logic                two_beat;
    logic [15:0]         pair_sel;
    logic [7:0]          e8;
    logic [4:0]          half_sum;
    logic [8:0]          byte_sum;
    cl16_pkg::out_item_t beat_first, beat_second;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Issue when the output register is empty or draining this cycle
    assign issue    = head_valid && (!m_valid_reg || m_ready);
    assign two_beat = (head.cls == cl16_pkg::CLS_PUSH) || (head.cls == cl16_pkg::CLS_ST_SP);
    assign pop      = issue && ((phase_reg == PH_SECOND) || !two_beat);

    assign pair_sel = pair_reg[head.sel];
    assign e8       = head.operand[7:0];
    assign half_sum = {1'b0, sp_reg[3:0]} + {1'b0, e8[3:0]};
    assign byte_sum = {1'b0, sp_reg[7:0]} + {1'b0, e8};

    // Execute the head instruction
    always_comb begin
        sp_next        = sp_reg;
        pair_next      = pair_reg;
        hold_addr_next = hold_addr_reg;
        hold_data_next = hold_data_reg;
        beat_first     = '0;
        beat_first.last = 1'b1;
        unique case (head.cls)
            cl16_pkg::CLS_LD_PAIR_IMM: begin
                pair_next[head.sel] = head.operand;
            end
            cl16_pkg::CLS_LD_SP_IMM: begin
                sp_next = head.operand;
            end
            cl16_pkg::CLS_ST_SP: begin
                beat_first.write_valid   = 1'b1;
                beat_first.write_address = head.operand;
                beat_first.write_data    = sp_reg[7:0];
                beat_first.last          = 1'b0;
                hold_addr_next           = head.operand + 16'd1;
                hold_data_next           = sp_reg[15:8];
            end
            cl16_pkg::CLS_POP: begin
                pair_next[head.sel] = (head.sel == cl16_pkg::PAIR_AF)
                                    ? (head.pop_word & cl16_pkg::AF_POP_MASK)
                                    : head.pop_word;
                sp_next = sp_reg + 16'd2;
            end
            cl16_pkg::CLS_PUSH: begin
                beat_first.write_valid   = 1'b1;
                beat_first.write_address = sp_reg - 16'd1;
                beat_first.write_data    = pair_sel[15:8];
                beat_first.last          = 1'b0;
                hold_addr_next           = sp_reg - 16'd2;
                hold_data_next           = pair_sel[7:0];
                sp_next                  = sp_reg - 16'd2;
            end
            cl16_pkg::CLS_LD_HL_SPE: begin
                // Signed offset; H and C from the unsigned low-byte add
                pair_next[cl16_pkg::PAIR_HL] = sp_reg + {{8{e8[7]}}, e8};
                pair_next[cl16_pkg::PAIR_AF] = {pair_reg[cl16_pkg::PAIR_AF][15:8],
                                                2'b00, half_sum[4], byte_sum[8], 4'b0000};
            end
            cl16_pkg::CLS_LD_SP_HL: begin
                sp_next = pair_reg[cl16_pkg::PAIR_HL];
            end
            default: begin
                beat_first.unsupported = 1'b1;
            end
        endcase
        beat_first.sp_value = sp_next;
        beat_first.hl_value = pair_next[cl16_pkg::PAIR_HL];
    end

    // Second write beat: state already holds the final values
    always_comb begin
        beat_second               = '0;
        beat_second.write_valid   = 1'b1;
        beat_second.write_address = hold_addr_reg;
        beat_second.write_data    = hold_data_reg;
        beat_second.last          = 1'b1;
        beat_second.sp_value      = sp_reg;
        beat_second.hl_value      = pair_reg[cl16_pkg::PAIR_HL];
    end

    // Phase, architectural state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FIRST;
            m_valid_reg <= 1'b0;
            sp_reg      <= '0;
            pair_reg    <= '{default: '0};
        end else begin
            if (issue) begin
                m_valid_reg <= 1'b1;
                if (phase_reg == PH_SECOND) begin
                    m_payload_reg <= beat_second;
                    phase_reg     <= PH_FIRST;
                end else begin
                    m_payload_reg <= beat_first;
                    sp_reg        <= sp_next;
                    pair_reg      <= pair_next;
                    hold_addr_reg <= hold_addr_next;
                    hold_data_reg <= hold_data_next;
                    phase_reg     <= two_beat ? PH_SECOND : PH_FIRST;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/cpu_16bit_load_unit.sv]
// 16-bit load group of an 8-bit CPU: LD rr,n16, LD SP,n16, LD (a16),SP,
// POP rr, PUSH rr, LD HL,SP+e8 and LD SP,HL, with BC, DE, HL, AF and SP held
// inside. Each s_ beat carries an opcode, the immediate word and the word read
// at SP; each m_ beat is one result. PUSH and LD (a16),SP give two byte-write
// beats (last on the second), every other opcode one beat; an unknown opcode
// gives one beat flagged unsupported and changes nothing.
// The accepting edge writes the decoded instruction into the queue; execute
// then moves it into the output register once that register is empty or
// draining. Single-beat opcodes go at one instruction per cycle while the
// receiver does not stall; PUSH and LD (a16),SP take two output beats, since
// the output register carries a single write byte per beat. The queue between
// decode and execute holds QUEUE_DEPTH instructions, so s_ready stays high
// while the receiver stalls until the queue fills. Reset (aresetn low at a
// clock edge) clears all register pairs, SP, the queue and the output valid.
`default_nettype none

module cpu_16bit_load_unit #(
    parameter int QUEUE_DEPTH = cl16_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire cl16_pkg::in_item_t   s_payload,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output cl16_pkg::out_item_t       m_payload
);

    logic                   queue_full;
    logic                   push;
    logic                   pop;
    logic                   head_valid;
    cl16_pkg::queue_entry_t entry;
    cl16_pkg::queue_entry_t head;

    cl16_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .queue_full (queue_full),
        .push       (push),
        .entry      (entry)
    );

    cl16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .entry_in   (entry),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    cl16_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule

`default_nettype wire

[rtl/cl16_checker.sv]
`default_nettype none

`include "cpu_16bit_load_unit_assert.svh"

module cl16_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire cl16_pkg::out_item_t m_payload
);

    // A stalled result beat holds
    `CL16_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // The first byte of a two-byte write is followed at once by the closing byte
    `CL16_ASSERT_NEXT(a_second_write, aclk, aresetn, m_valid && m_ready && m_payload.write_valid && !m_payload.last, m_valid && m_payload.write_valid && m_payload.last)

    // An unsupported opcode gives a lone beat with no write
    `CL16_ASSERT_SAME(a_unsup_alone, aclk, aresetn, m_valid && m_payload.unsupported, m_payload.last && !m_payload.write_valid)

    // Only a byte write can be followed by another beat of the same instruction
    `CL16_ASSERT_SAME(a_open_is_write, aclk, aresetn, m_valid && !m_payload.last, m_payload.write_valid && !m_payload.unsupported)

endmodule

bind cpu_16bit_load_unit cl16_checker u_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire

[tb/testbench.sv]
module testbench;

    // Row of the directed table: one instruction, plus a typed result
    // where the value is obvious without running the predictor
    typedef struct packed {
        logic [7:0]          opcode;
        logic [15:0]         operand_word;
        logic [15:0]         pop_word;
        logic                typed;
        cl16_pkg::out_item_t fixed_beat;
    } directed_row_t;

    localparam int N_DIRECTED = 25;
    localparam int PHASE_ITEMS = 400;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    cl16_pkg::in_item_t  s_payload = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    cl16_pkg::out_item_t m_payload;

    // Register file as seen by the predictor, indexed by opcode bits 5..4
    logic [15:0] pair_file [4] = '{16'h0, 16'h0, 16'h0, 16'h0};
    logic [15:0] stack_word = 16'h0;
    cl16_pkg::out_item_t expected_beats [$];

    int          error_count = 0;
    int          beats_sent = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    logic        hold_active = 1'b0;

    logic [7:0]  load_ops [15] = '{
        cl16_pkg::OP_LD_BC_N16, cl16_pkg::OP_LD_DE_N16, cl16_pkg::OP_LD_HL_N16,
        cl16_pkg::OP_LD_SP_N16, cl16_pkg::OP_LD_A16_SP,
        cl16_pkg::OP_POP_BC, cl16_pkg::OP_POP_DE, cl16_pkg::OP_POP_HL,
        cl16_pkg::OP_POP_AF,
        cl16_pkg::OP_PUSH_BC, cl16_pkg::OP_PUSH_DE, cl16_pkg::OP_PUSH_HL,
        cl16_pkg::OP_PUSH_AF,
        cl16_pkg::OP_LD_HL_SPE, cl16_pkg::OP_LD_SP_HL
    };

    // Directed part: extremes, every opcode, stack wrap, POP AF nibble
    // clearing, signed e8 both ways with carries, unknown opcodes
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00, 16'h0000, 16'h0000, 1'b1,
          '{1'b0, 16'h0, 8'h0, 1'b1, 1'b1, 16'h0000, 16'h0000}},
        '{cl16_pkg::OP_LD_SP_N16, 16'hFFFF, 16'h0000, 1'b1,
          '{1'b0, 16'h0, 8'h0, 1'b1, 1'b0, 16'hFFFF, 16'h0000}},
        '{cl16_pkg::OP_LD_HL_N16, 16'hFFFF, 16'h0000, 1'b1,
          '{1'b0, 16'h0, 8'h0, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF}},
        '{8'hFF, 16'hFFFF, 16'hFFFF, 1'b1,
          '{1'b0, 16'h0, 8'h0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF}},
        '{cl16_pkg::OP_LD_BC_N16, 16'h8001, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_LD_DE_N16, 16'h7FFE, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_PUSH_BC,   16'h0000, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_PUSH_DE,   16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{cl16_pkg::OP_PUSH_HL,   16'h0000, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_LD_SP_N16, 16'h0001, 16'h0000, 1'b1,
          '{1'b0, 16'h0, 8'h0, 1'b1, 1'b0, 16'h0001, 16'hFFFF}},
        '{cl16_pkg::OP_PUSH_HL,   16'h0000, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_POP_BC,    16'h0000, 16'hFFFF, 1'b0, '0},
        '{cl16_pkg::OP_POP_DE,    16'hFFFF, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_POP_AF,    16'h0000, 16'hFFFF, 1'b0, '0},
        '{cl16_pkg::OP_PUSH_AF,   16'h0000, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_POP_HL,    16'h0000, 16'h1234, 1'b0, '0},
        '{cl16_pkg::OP_LD_A16_SP, 16'hFFFF, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_LD_A16_SP, 16'h0000, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_LD_SP_N16, 16'h00FF, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_LD_HL_SPE, 16'hFF01, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_PUSH_AF,   16'h0000, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_LD_HL_SPE, 16'h0080, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_LD_HL_SPE, 16'h007F, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_LD_SP_HL,  16'h0000, 16'h0000, 1'b0, '0},
        '{cl16_pkg::OP_PUSH_AF,   16'h0000, 16'h0000, 1'b0, '0}
    };

    cpu_16bit_load_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Works out the result beats of one instruction and queues them
    task automatic execute_load_op(input cl16_pkg::in_item_t instr);
        logic [15:0] word;
        logic [15:0] pushed;
        logic [7:0]  e8;
        logic [8:0]  low_sum;
        logic [4:0]  nibble_sum;
        logic [15:0] wr_addr [2];
        logic [7:0]  wr_data [2];
        int          n_writes;
        cl16_pkg::out_item_t beat;
        word = instr.operand_word;
        e8 = word[7:0];
        n_writes = 0;
        beat = '0;
        beat.last = 1'b1;
        case (instr.opcode)
            cl16_pkg::OP_LD_BC_N16, cl16_pkg::OP_LD_DE_N16, cl16_pkg::OP_LD_HL_N16: begin
                pair_file[instr.opcode[5:4]] = word;
            end
            cl16_pkg::OP_LD_SP_N16: begin
                stack_word = word;
            end
            cl16_pkg::OP_LD_A16_SP: begin
                n_writes = 2;
                wr_addr[0] = word;
                wr_data[0] = stack_word[7:0];
                wr_addr[1] = word + 16'd1;
                wr_data[1] = stack_word[15:8];
            end
            cl16_pkg::OP_POP_BC, cl16_pkg::OP_POP_DE,
            cl16_pkg::OP_POP_HL, cl16_pkg::OP_POP_AF: begin
                pair_file[instr.opcode[5:4]] = (instr.opcode == cl16_pkg::OP_POP_AF) ?
                    (instr.pop_word & cl16_pkg::AF_POP_MASK) : instr.pop_word;
                stack_word = stack_word + 16'd2;
            end
            cl16_pkg::OP_PUSH_BC, cl16_pkg::OP_PUSH_DE,
            cl16_pkg::OP_PUSH_HL, cl16_pkg::OP_PUSH_AF: begin
                pushed = pair_file[instr.opcode[5:4]];
                n_writes = 2;
                wr_addr[0] = stack_word - 16'd1;
                wr_data[0] = pushed[15:8];
                wr_addr[1] = stack_word - 16'd2;
                wr_data[1] = pushed[7:0];
                stack_word = stack_word - 16'd2;
            end
            cl16_pkg::OP_LD_HL_SPE: begin
                // flags come from the unsigned low-byte add; Z and N cleared
                low_sum = {1'b0, stack_word[7:0]} + {1'b0, e8};
                nibble_sum = {1'b0, stack_word[3:0]} + {1'b0, e8[3:0]};
                pair_file[cl16_pkg::PAIR_HL] = stack_word + {{8{e8[7]}}, e8};
                pair_file[cl16_pkg::PAIR_AF] = {pair_file[cl16_pkg::PAIR_AF][15:8], 2'b00,
                                                nibble_sum[4], low_sum[8], 4'b0000};
            end
            cl16_pkg::OP_LD_SP_HL: begin
                stack_word = pair_file[cl16_pkg::PAIR_HL];
            end
            default: begin
                beat.unsupported = 1'b1;
            end
        endcase
        beat.sp_value = stack_word;
        beat.hl_value = pair_file[cl16_pkg::PAIR_HL];
        if (n_writes == 0) begin
            expected_beats.push_back(beat);
        end else begin
            for (int k = 0; k < 2; k++) begin
                beat.write_valid = 1'b1;
                beat.write_address = wr_addr[k];
                beat.write_data = wr_data[k];
                beat.last = (k == 1);
                expected_beats.push_back(beat);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task automatic check_beat(input cl16_pkg::out_item_t got);
        cl16_pkg::out_item_t want;
        if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing expected", got));
            return;
        end
        want = expected_beats.pop_front();
        compare_field("write_valid", 16'(got.write_valid), 16'(want.write_valid));
        compare_field("write_address", got.write_address, want.write_address);
        compare_field("write_data", 16'(got.write_data), 16'(want.write_data));
        compare_field("last", 16'(got.last), 16'(want.last));
        compare_field("unsupported", 16'(got.unsupported), 16'(want.unsupported));
        compare_field("sp_value", got.sp_value, want.sp_value);
        compare_field("hl_value", got.hl_value, want.hl_value);
    endtask

    // Offers one instruction beat, with random idle cycles ahead of it
    task automatic send_instr(input cl16_pkg::in_item_t instr);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= instr;
        do @(posedge aclk); while (!s_ready);
        execute_load_op(instr);
        beats_sent++;
    endtask

    function automatic logic [15:0] random_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly load-group opcodes, the odd arbitrary byte
    function automatic cl16_pkg::in_item_t random_instr();
        cl16_pkg::in_item_t instr;
        if ($urandom_range(9) == 0)
            instr.opcode = 8'($urandom_range(255));
        else
            instr.opcode = load_ops[$urandom_range(14)];
        instr.operand_word = random_word();
        instr.pop_word = random_word();
        return instr;
    endfunction

    // Result side: check each beat, stall at random or during the hold-off
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_beat(m_payload);
        if (hold_active)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Long receiver hold-off early on, so the queue fills and s_ready drops
    initial begin
        wait (beats_sent >= 60);
        @(posedge aclk);
        hold_active <= 1'b1;
        repeat (80) @(posedge aclk);
        hold_active <= 1'b0;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        cl16_pkg::in_item_t instr;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table; typed rows override the predicted beat
        for (int r = 0; r < N_DIRECTED; r++) begin
            instr.opcode = directed_rows[r].opcode;
            instr.operand_word = directed_rows[r].operand_word;
            instr.pop_word = directed_rows[r].pop_word;
            send_instr(instr);
            if (directed_rows[r].typed)
                expected_beats[$] = directed_rows[r].fixed_beat;
        end

        // Random phases: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
                1: begin sender_idle_pct = 55; receiver_stall_pct <= 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct <= 55; end
                default: begin
                    sender_idle_pct = 27;
                    receiver_stall_pct <= 27;
                end
            endcase
            repeat (PHASE_ITEMS) send_instr(random_instr());
        end
        s_valid <= 1'b0;

        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/cl16_pkg.sv
rtl/cl16_front.sv
rtl/cl16_queue.sv
rtl/cl16_back.sv
rtl/cpu_16bit_load_unit.sv
rtl/cl16_checker.sv
tb/testbench.sv
